FILE: rtl/sensor_median_wma_hysteresis_macros.svh
// Assertion macros shared by the sensor conditioning checker.
`ifndef SENSOR_MEDIAN_WMA_HYSTERESIS_MACROS_SVH
`define SENSOR_MEDIAN_WMA_HYSTERESIS_MACROS_SVH

// Clocked assertion, disabled while reset is held low.
`define SMWH_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define SMWH_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/smwh_pkg.sv
// Package: shared constants and state types of the sensor conditioning channel.
`timescale 1ns / 1ps

package smwh_pkg;

    localparam int DEF_WINDOW      = 5;
    localparam int DEF_SAMPLE_BITS = 16;

    // smoothing weight in percent
    localparam int             PCT_BITS  = 7;
    localparam logic [6:0]     PCT_FULL  = 7'd100;
    localparam logic [6:0]     PCT_RESET = 7'd50;

    // configuration register indexes
    localparam int             CFG_IDX_BITS = 3;
    localparam logic [2:0]     REG_CLAMP_MIN  = 3'd0;
    localparam logic [2:0]     REG_CLAMP_MAX  = 3'd1;
    localparam logic [2:0]     REG_SMOOTH_PCT = 3'd2;
    localparam logic [2:0]     REG_ALERT_LOW  = 3'd3;
    localparam logic [2:0]     REG_ALERT_HIGH = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MEDIAN,
        ST_AVG,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        AV_IDLE,
        AV_MUL_A,
        AV_MUL_B,
        AV_DIV
    } t_avg_state;

endpackage

FILE: rtl/sensor_median_wma_hysteresis.sv
// Top level: clamp, sliding median, weighted average and alert of one sensor channel.
// Steps: accept, median scan one window entry per cycle, average unit (two weighted
// products and a reciprocal divide; skipped for the first sample after reset), then the
// result register, which waits while the output is stalled. One sample at a time: the
// next is accepted only once the last result is loaded into the result register.
// Reset: synchronous, active low; empties the window, clears the average and the alert.
`timescale 1ns / 1ps

module sensor_median_wma_hysteresis #(
    parameter int WINDOW      = smwh_pkg::DEF_WINDOW,
    parameter int SAMPLE_BITS = smwh_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration write port
    input  logic                                  i_cfg_we,
    input  logic [smwh_pkg::CFG_IDX_BITS-1:0]     i_cfg_idx,
    input  logic [SAMPLE_BITS-1:0]                i_cfg_data,
    // sample channel
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic signed [SAMPLE_BITS-1:0]         i_sample,
    // result channel
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic signed [SAMPLE_BITS-1:0]         o_clamped,
    output logic signed [SAMPLE_BITS-1:0]         o_median_value,
    output logic signed [SAMPLE_BITS-1:0]         o_smoothed,
    output logic                                  o_alert
);

    localparam int CW = $clog2(WINDOW + 1);
    localparam int IW = (WINDOW > 1) ? $clog2(WINDOW) : 1;

    localparam logic signed [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic signed [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

    // configuration registers
    logic signed [SAMPLE_BITS-1:0]     r_clamp_min;
    logic signed [SAMPLE_BITS-1:0]     r_clamp_max;
    logic [smwh_pkg::PCT_BITS-1:0]     r_pct;
    logic signed [SAMPLE_BITS-1:0]     r_alert_low;
    logic signed [SAMPLE_BITS-1:0]     r_alert_high;

    // channel state
    smwh_pkg::t_state                  r_state, n_state;
    logic signed [SAMPLE_BITS-1:0]     r_win [WINDOW];
    logic [IW-1:0]                     r_wslot;
    logic [CW-1:0]                     r_fill;
    logic signed [SAMPLE_BITS-1:0]     r_sat;
    logic signed [SAMPLE_BITS-1:0]     r_avg;
    logic                              r_seeded;
    logic                              r_alert;
    logic                              r_med_start;
    logic                              r_avg_start;

    // result register
    logic                              r_out_valid;
    logic signed [SAMPLE_BITS-1:0]     r_out_clamped;
    logic signed [SAMPLE_BITS-1:0]     r_out_median;
    logic signed [SAMPLE_BITS-1:0]     r_out_smoothed;
    logic                              r_out_alert;

    logic                              w_accept;
    logic signed [SAMPLE_BITS-1:0]     w_sat;
    logic [smwh_pkg::PCT_BITS-1:0]     w_alpha;
    logic                              w_med_done;
    logic signed [SAMPLE_BITS-1:0]     w_median;
    logic                              w_avg_done;
    logic signed [SAMPLE_BITS-1:0]     w_avg_calc;
    logic                              w_avg_upd;
    logic signed [SAMPLE_BITS-1:0]     w_avg_new;
    logic                              w_alert_new;
    logic                              w_out_free;
    logic                              w_out_load;

    // Saturation: below-min wins over above-max, so crossed bounds give clamp_min
    // for low samples and clamp_max for the rest that exceed it.
    assign w_sat = (i_sample < r_clamp_min) ? r_clamp_min :
                   (i_sample > r_clamp_max) ? r_clamp_max : i_sample;

    // weights above 100 percent act as 100
    assign w_alpha = (r_pct > smwh_pkg::PCT_FULL) ? smwh_pkg::PCT_FULL : r_pct;

    assign w_accept   = i_valid && (r_state == smwh_pkg::ST_IDLE);
    assign w_out_free = !r_out_valid || !i_stall;

    // First sample seeds the average with the clamped value; later ones take
    // the weighted mix from the average unit.
    assign w_avg_upd = ((r_state == smwh_pkg::ST_MEDIAN) && w_med_done && !r_seeded) ||
                       ((r_state == smwh_pkg::ST_AVG) && w_avg_done);
    assign w_avg_new = (r_state == smwh_pkg::ST_AVG) ? w_avg_calc : r_sat;

    // hysteresis: set above high, hold while at or above low
    assign w_alert_new = r_alert ? (w_avg_new >= r_alert_low) : (w_avg_new > r_alert_high);

    // sequencer: one sample at a time, result parked until the output register frees
    always_comb begin
        n_state    = r_state;
        w_out_load = 1'b0;
        unique case (r_state)
            smwh_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_state = smwh_pkg::ST_MEDIAN;
                end
            end
            smwh_pkg::ST_MEDIAN: begin
                if (w_med_done) begin
                    n_state = r_seeded ? smwh_pkg::ST_AVG : smwh_pkg::ST_DONE;
                end
            end
            smwh_pkg::ST_AVG: begin
                if (w_avg_done) begin
                    n_state = smwh_pkg::ST_DONE;
                end
            end
            smwh_pkg::ST_DONE: begin
                if (w_out_free) begin
                    w_out_load = 1'b1;
                    n_state    = smwh_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = smwh_pkg::ST_IDLE;
            end
        endcase
    end

    // configuration writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clamp_min  <= SMIN;
            r_clamp_max  <= SMAX;
            r_pct        <= smwh_pkg::PCT_RESET;
            r_alert_low  <= '0;
            r_alert_high <= SMAX;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                smwh_pkg::REG_CLAMP_MIN:  r_clamp_min  <= $signed(i_cfg_data);
                smwh_pkg::REG_CLAMP_MAX:  r_clamp_max  <= $signed(i_cfg_data);
                smwh_pkg::REG_SMOOTH_PCT: r_pct        <= i_cfg_data[smwh_pkg::PCT_BITS-1:0];
                smwh_pkg::REG_ALERT_LOW:  r_alert_low  <= $signed(i_cfg_data);
                smwh_pkg::REG_ALERT_HIGH: r_alert_high <= $signed(i_cfg_data);
                default: begin
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= smwh_pkg::ST_IDLE;
            r_wslot     <= '0;
            r_fill      <= '0;
            r_avg       <= '0;
            r_seeded    <= 1'b0;
            r_alert     <= 1'b0;
            r_med_start <= 1'b0;
            r_avg_start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_med_start <= w_accept;
            r_avg_start <= (r_state == smwh_pkg::ST_MEDIAN) && w_med_done && r_seeded;
            if (w_accept) begin
                r_wslot <= (r_wslot == IW'(WINDOW - 1)) ? '0 : r_wslot + 1'b1;
                if (r_fill < CW'(WINDOW)) begin
                    r_fill <= r_fill + 1'b1;
                end
            end
            if (w_avg_upd) begin
                r_avg    <= w_avg_new;
                r_seeded <= 1'b1;
                r_alert  <= w_alert_new;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ring store and payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_win[r_wslot] <= w_sat;
            r_sat          <= w_sat;
        end
        if (w_out_load) begin
            r_out_clamped  <= r_sat;
            r_out_median   <= w_median;
            r_out_smoothed <= r_avg;
            r_out_alert    <= r_alert;
        end
    end

    smwh_median #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_median (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_med_start),
        .i_win    (r_win),
        .i_fill   (r_fill),
        .o_done   (w_med_done),
        .o_median (w_median)
    );

    smwh_wavg #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_wavg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_avg_start),
        .i_alpha  (w_alpha),
        .i_median (w_median),
        .i_avg    (r_avg),
        .o_done   (w_avg_done),
        .o_avg    (w_avg_calc)
    );

    assign o_stall        = (r_state != smwh_pkg::ST_IDLE);
    assign o_valid        = r_out_valid;
    assign o_clamped      = r_out_clamped;
    assign o_median_value = r_out_median;
    assign o_smoothed     = r_out_smoothed;
    assign o_alert        = r_out_alert;

endmodule

FILE: rtl/smwh_median.sv
// Median selector: tests one window entry per cycle for rank fill/2.
`timescale 1ns / 1ps

module smwh_median #(
    parameter int WINDOW      = smwh_pkg::DEF_WINDOW,
    parameter int SAMPLE_BITS = smwh_pkg::DEF_SAMPLE_BITS,
    localparam int CW         = $clog2(WINDOW + 1),
    localparam int IW         = (WINDOW > 1) ? $clog2(WINDOW) : 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic signed [SAMPLE_BITS-1:0] i_win [WINDOW],
    input  logic [CW-1:0]                 i_fill,
    output logic                          o_done,
    output logic signed [SAMPLE_BITS-1:0] o_median
);

    logic                          r_busy;
    logic [IW-1:0]                 r_idx;
    logic                          r_done;
    logic signed [SAMPLE_BITS-1:0] r_med;

    logic signed [SAMPLE_BITS-1:0] w_cand;
    logic [CW-1:0]                 w_lt;
    logic [CW-1:0]                 w_le;
    logic [CW-1:0]                 w_rank;
    logic                          w_hit;

    // candidate is the median when rank fill/2 falls in its run of equal values
    always_comb begin
        w_cand = i_win[r_idx];
        w_lt   = '0;
        w_le   = '0;
        for (int j = 0; j < WINDOW; j++) begin
            if (CW'(j) < i_fill) begin
                if (i_win[j] < w_cand) begin
                    w_lt = w_lt + 1'b1;
                end
                if (i_win[j] <= w_cand) begin
                    w_le = w_le + 1'b1;
                end
            end
        end
        w_rank = i_fill >> 1;
        w_hit  = (w_lt <= w_rank) && (w_rank < w_le);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (r_busy) begin
                if (w_hit) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy && w_hit) begin
            r_med <= w_cand;
        end
    end

    assign o_done   = r_done;
    assign o_median = r_med;

endmodule

FILE: rtl/smwh_wavg.sv
// Weighted average: one shared multiplier for both weights and a reciprocal divide by 100.
`timescale 1ns / 1ps

module smwh_wavg #(
    parameter int SAMPLE_BITS = smwh_pkg::DEF_SAMPLE_BITS,
    localparam int PW         = SAMPLE_BITS + 8,
    localparam int MW         = SAMPLE_BITS + 7,
    localparam int RK         = SAMPLE_BITS + 13,
    localparam int XW         = 2 * PW
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [smwh_pkg::PCT_BITS-1:0]    i_alpha,
    input  logic signed [SAMPLE_BITS-1:0]    i_median,
    input  logic signed [SAMPLE_BITS-1:0]    i_avg,
    output logic                             o_done,
    output logic signed [SAMPLE_BITS-1:0]    o_avg
);

    // ceil(2**RK / 100): floor quotient is exact for every weighted-sum magnitude
    localparam logic [63:0]   RECIP_WIDE = ((64'd1 << RK) + 64'(smwh_pkg::PCT_FULL) - 64'd1)
                                           / 64'(smwh_pkg::PCT_FULL);
    localparam logic [MW-1:0] RECIP      = RECIP_WIDE[MW-1:0];

    smwh_pkg::t_avg_state r_state, n_state;

    logic signed [PW-1:0]          r_acc, n_acc;
    logic [MW-1:0]                 r_mag, n_mag;
    logic                          r_neg, n_neg;
    logic                          r_done, n_done;
    logic signed [SAMPLE_BITS-1:0] r_avg, n_avg;

    logic [smwh_pkg::PCT_BITS-1:0] w_coef;
    logic signed [PW-1:0]          w_op_a;
    logic signed [PW-1:0]          w_op_b;
    logic signed [XW-1:0]          w_prod;
    logic signed [PW-1:0]          w_sum;
    logic [PW-1:0]                 w_mag;
    logic [SAMPLE_BITS-1:0]        w_quot;

    assign w_coef = (r_state == smwh_pkg::AV_MUL_A) ? i_alpha
                                                    : (smwh_pkg::PCT_FULL - i_alpha);

    // single multiplier, operands picked by phase
    always_comb begin
        case (r_state)
            smwh_pkg::AV_MUL_A: begin
                w_op_a = PW'(i_median);
                w_op_b = $signed({{(PW - smwh_pkg::PCT_BITS){1'b0}}, w_coef});
            end
            smwh_pkg::AV_DIV: begin
                w_op_a = $signed({1'b0, r_mag});
                w_op_b = $signed({1'b0, RECIP});
            end
            default: begin
                w_op_a = PW'(i_avg);
                w_op_b = $signed({{(PW - smwh_pkg::PCT_BITS){1'b0}}, w_coef});
            end
        endcase
    end

    assign w_prod = XW'(w_op_a) * XW'(w_op_b);
    assign w_sum  = r_acc + $signed(w_prod[PW-1:0]);
    assign w_mag  = w_sum[PW-1] ? PW'(-w_sum) : PW'(w_sum);
    assign w_quot = w_prod[RK +: SAMPLE_BITS];

    always_comb begin
        n_state = r_state;
        n_acc   = r_acc;
        n_mag   = r_mag;
        n_neg   = r_neg;
        n_done  = 1'b0;
        n_avg   = r_avg;
        unique case (r_state)
            smwh_pkg::AV_IDLE: begin
                if (i_start) begin
                    n_state = smwh_pkg::AV_MUL_A;
                end
            end
            smwh_pkg::AV_MUL_A: begin
                n_acc   = $signed(w_prod[PW-1:0]);
                n_state = smwh_pkg::AV_MUL_B;
            end
            smwh_pkg::AV_MUL_B: begin
                n_neg   = w_sum[PW-1];
                n_mag   = w_mag[MW-1:0];
                n_state = smwh_pkg::AV_DIV;
            end
            smwh_pkg::AV_DIV: begin
                // divide on the magnitude: truncates toward zero
                n_avg   = r_neg ? $signed(-w_quot) : $signed(w_quot);
                n_done  = 1'b1;
                n_state = smwh_pkg::AV_IDLE;
            end
            default: begin
                n_state = smwh_pkg::AV_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= smwh_pkg::AV_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_mag <= n_mag;
        r_neg <= n_neg;
        r_avg <= n_avg;
    end

    assign o_done = r_done;
    assign o_avg  = r_avg;

endmodule

FILE: rtl/smwh_checker.sv
// Port-level checker for the sensor conditioning channel, bound to the top level.
`timescale 1ns / 1ps
`include "sensor_median_wma_hysteresis_macros.svh"

module smwh_checker #(
    parameter int SAMPLE_BITS = smwh_pkg::DEF_SAMPLE_BITS
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_stall,
    input logic                          o_valid,
    input logic                          i_stall,
    input logic signed [SAMPLE_BITS-1:0] o_clamped,
    input logic signed [SAMPLE_BITS-1:0] o_median_value,
    input logic signed [SAMPLE_BITS-1:0] o_smoothed,
    input logic                          o_alert
);

    // one sample in flight: the block closes its input right after a beat
    `SMWH_ASSERT(a_busy_after_accept, i_clk, i_rst_n, i_valid && !o_stall |=> o_stall, "input not closed after accept")

    // reset empties the result register
    `SMWH_ASSERT_NR(a_reset_clears_out, i_clk, !i_rst_n |=> !o_valid, "result valid after reset")

    `SMWH_ASSERT(a_out_valid_holds, i_clk, i_rst_n, o_valid && i_stall |=> o_valid, "result dropped while stalled")

    `SMWH_ASSERT(a_out_payload_holds, i_clk, i_rst_n, o_valid && i_stall |=> $stable(o_clamped) && $stable(o_median_value) && $stable(o_smoothed) && $stable(o_alert), "result changed while stalled")

endmodule

bind sensor_median_wma_hysteresis smwh_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_smwh_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_stall        (o_stall),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_clamped      (o_clamped),
    .o_median_value (o_median_value),
    .o_smoothed     (o_smoothed),
    .o_alert        (o_alert)
);
